### rtl/core/potq_pkg.sv
package potq_pkg;

  // request codes
  localparam logic REQ_ADD      = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_ADDED      = 2'd0;
  localparam logic [1:0] STAT_DISPATCHED = 2'd1;
  localparam logic [1:0] STAT_EMPTY      = 2'd2;
  localparam logic [1:0] STAT_FULL       = 2'd3;

  localparam int ID_W    = 8;
  localparam int PRI_W   = 8;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;
  localparam int SUM_W   = 48;
  localparam int DONE_W  = 16;
  localparam int LEVEL_W = 5;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
    logic [ID_W-1:0]    id;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic exec;     // update the queue and elapsed time
    logic finish;   // update the sums and load the result register
  } cmd_t;

endpackage

### rtl/core/potq_ctrl.sv
module potq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output potq_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_ACCUM = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_finish;
  logic       take_in;

  // result register is free or being emptied this cycle
  assign can_finish = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE) || ((state_r == ST_ACCUM) && can_finish);
  assign take_in    = in_valid && in_ready;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = take_in;
    cmd.exec    = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take_in) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (can_finish) begin
          cmd.finish = 1'b1;
          state_nxt  = take_in ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.finish) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_exec_to_accum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |=> state_r == ST_ACCUM)
    else $error("exec state not followed by accumulate");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_EXEC)
    else $error("accepted request not executed");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready && state_r == ST_ACCUM |=> state_r == ST_ACCUM)
    else $error("pending result would be overwritten");
`endif

endmodule

### rtl/core/potq_dp.sv
module potq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  potq_pkg::cmd_t                  cmd,
  input  logic                            in_req_type,
  input  logic [potq_pkg::ID_W-1:0]       in_task_id,
  input  logic [potq_pkg::PRI_W-1:0]      in_task_priority,
  input  logic [potq_pkg::BURST_W-1:0]    in_task_burst,
  output logic [1:0]                      out_status,
  output logic [potq_pkg::ID_W-1:0]       out_task_id,
  output logic [potq_pkg::BURST_W-1:0]    out_burst,
  output logic [potq_pkg::TIME_W-1:0]     out_finish_time,
  output logic [potq_pkg::TIME_W-1:0]     out_wait_time,
  output logic [potq_pkg::SUM_W-1:0]      out_turnaround_sum,
  output logic [potq_pkg::SUM_W-1:0]      out_waiting_sum,
  output logic [potq_pkg::DONE_W-1:0]     out_done_count,
  output logic [potq_pkg::LEVEL_W-1:0]    out_queue_level
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // captured request
  logic                           req_r;
  logic [potq_pkg::ID_W-1:0]      id_r;
  logic [potq_pkg::PRI_W-1:0]     pri_r;
  logic [potq_pkg::BURST_W-1:0]   burst_r;

  // cell row, ordered head first
  potq_pkg::slot_t slot_r   [QUEUE_DEPTH];
  potq_pkg::slot_t slot_nxt [QUEUE_DEPTH];
  potq_pkg::slot_t new_slot;
  logic [QUEUE_DEPTH-1:0] ge;

  logic [CNT_W-1:0]               count_r;
  logic [potq_pkg::TIME_W-1:0]    elapsed_r;
  logic [potq_pkg::SUM_W-1:0]     turn_r, wsum_r;
  logic [potq_pkg::DONE_W-1:0]    done_r;

  // per-request results between exec and finish
  logic [1:0]                     status_r;
  logic [potq_pkg::ID_W-1:0]      hd_id_r;
  logic [potq_pkg::BURST_W-1:0]   hd_burst_r;
  logic [potq_pkg::TIME_W-1:0]    fin_r, wt_r;

  logic                           full, empty, do_ins, do_pop;
  logic [potq_pkg::TIME_W:0]      el_sum;
  logic [potq_pkg::TIME_W-1:0]    el_new, wt_new;
  logic [potq_pkg::SUM_W:0]       turn_sum, wsum_sum;
  logic [potq_pkg::SUM_W-1:0]     turn_nxt, wsum_nxt;
  logic [potq_pkg::DONE_W-1:0]    done_nxt;
  logic                           dispatched;
  logic [31:0]                    level_ext;

  assign full   = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty  = count_r == '0;
  assign do_ins = cmd.exec && (req_r == potq_pkg::REQ_ADD) && !full;
  assign do_pop = cmd.exec && (req_r == potq_pkg::REQ_DISPATCH) && !empty;

  assign new_slot.id    = id_r;
  assign new_slot.pri   = pri_r;
  assign new_slot.burst = burst_r;

  // held tasks that stay ahead of the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CNT_W'(i) < count_r) && (slot_r[i].pri >= pri_r);
    end
  end

  always_comb begin
    slot_nxt = slot_r;
    if (do_ins) begin
      if (!ge[0]) slot_nxt[0] = new_slot;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!ge[i]) slot_nxt[i] = ge[i-1] ? new_slot : slot_r[i-1];
      end
    end else if (do_pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
    end
  end

  // saturating elapsed time; wait is the old elapsed time unless clipped
  assign el_sum = {1'b0, elapsed_r} + (potq_pkg::TIME_W + 1)'(slot_r[0].burst);
  assign el_new = el_sum[potq_pkg::TIME_W] ? '1 : el_sum[potq_pkg::TIME_W-1:0];
  assign wt_new = el_sum[potq_pkg::TIME_W]
                  ? ~potq_pkg::TIME_W'(slot_r[0].burst) : elapsed_r;

  assign dispatched = status_r == potq_pkg::STAT_DISPATCHED;
  assign turn_sum   = {1'b0, turn_r} + (potq_pkg::SUM_W + 1)'(fin_r);
  assign wsum_sum   = {1'b0, wsum_r} + (potq_pkg::SUM_W + 1)'(wt_r);

  always_comb begin
    turn_nxt = turn_r;
    wsum_nxt = wsum_r;
    done_nxt = done_r;
    if (dispatched) begin
      turn_nxt = turn_sum[potq_pkg::SUM_W] ? '1 : turn_sum[potq_pkg::SUM_W-1:0];
      wsum_nxt = wsum_sum[potq_pkg::SUM_W] ? '1 : wsum_sum[potq_pkg::SUM_W-1:0];
      if (done_r != '1) done_nxt = done_r + potq_pkg::DONE_W'(1);
    end
  end

  assign level_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      id_r    <= in_task_id;
      pri_r   <= in_task_priority;
      burst_r <= in_task_burst;
    end
    slot_r <= slot_nxt;
    if (cmd.exec) begin
      hd_id_r    <= '0;
      hd_burst_r <= '0;
      fin_r      <= '0;
      wt_r       <= '0;
      if (req_r == potq_pkg::REQ_ADD) begin
        status_r <= full ? potq_pkg::STAT_FULL : potq_pkg::STAT_ADDED;
      end else if (empty) begin
        status_r <= potq_pkg::STAT_EMPTY;
      end else begin
        status_r   <= potq_pkg::STAT_DISPATCHED;
        hd_id_r    <= slot_r[0].id;
        hd_burst_r <= slot_r[0].burst;
        fin_r      <= el_new;
        wt_r       <= wt_new;
      end
    end
    if (cmd.finish) begin
      out_status         <= status_r;
      out_task_id        <= hd_id_r;
      out_burst          <= hd_burst_r;
      out_finish_time    <= fin_r;
      out_wait_time      <= wt_r;
      out_turnaround_sum <= turn_nxt;
      out_waiting_sum    <= wsum_nxt;
      out_done_count     <= done_nxt;
      out_queue_level    <= level_ext[potq_pkg::LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      elapsed_r <= '0;
      turn_r    <= '0;
      wsum_r    <= '0;
      done_r    <= '0;
    end else begin
      if (do_ins) count_r <= count_r + CNT_W'(1);
      if (do_pop) begin
        count_r   <= count_r - CNT_W'(1);
        elapsed_r <= el_new;
      end
      if (cmd.finish) begin
        turn_r <= turn_nxt;
        wsum_r <= wsum_nxt;
        done_r <= done_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && full && (req_r == potq_pkg::REQ_ADD) |=> $stable(count_r))
    else $error("rejected add changed the queue level");
`endif

endmodule

### rtl/core/priority_ordered_task_queue.sv
// each request is captured, then the cell row and elapsed time are updated,
// then the saturating 48-bit sums are updated and the result register loaded,
// which waits while the previous result is still held and not taken
// the next request is taken in the cycle its predecessor's result is loaded
// reset (rst_n, synchronous, active low) empties the queue and clears time,
// sums and done count; task slot contents are not reset
module priority_ordered_task_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [potq_pkg::ID_W-1:0]       in_task_id,
  input  logic [potq_pkg::PRI_W-1:0]      in_task_priority,
  input  logic [potq_pkg::BURST_W-1:0]    in_task_burst,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [potq_pkg::ID_W-1:0]       out_task_id,
  output logic [potq_pkg::BURST_W-1:0]    out_burst,
  output logic [potq_pkg::TIME_W-1:0]     out_finish_time,
  output logic [potq_pkg::TIME_W-1:0]     out_wait_time,
  output logic [potq_pkg::SUM_W-1:0]      out_turnaround_sum,
  output logic [potq_pkg::SUM_W-1:0]      out_waiting_sum,
  output logic [potq_pkg::DONE_W-1:0]     out_done_count,
  output logic [potq_pkg::LEVEL_W-1:0]    out_queue_level
);

  // command bundle from the sequencer to the datapath
  potq_pkg::cmd_t cmd;

  // sequencer: captures a request transaction, steps it through the
  // queue update and the accumulate step, and owns the result valid flag
  potq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: the priority-sorted shifting cell row, elapsed time,
  // saturating sums and the result register
  potq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_task_id         (in_task_id),
    .in_task_priority   (in_task_priority),
    .in_task_burst      (in_task_burst),
    .out_status         (out_status),
    .out_task_id        (out_task_id),
    .out_burst          (out_burst),
    .out_finish_time    (out_finish_time),
    .out_wait_time      (out_wait_time),
    .out_turnaround_sum (out_turnaround_sum),
    .out_waiting_sum    (out_waiting_sum),
    .out_done_count     (out_done_count),
    .out_queue_level    (out_queue_level)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// priority task queue: every request transaction is run through a scheduling
// model kept here (ordered task list, elapsed ticks, saturating sums) and the
// result transaction that comes back is compared field by field
module tb;

  localparam int TB_DEPTH = 16;

  // one result transaction as the block should present it
  typedef struct packed {
    logic [1:0]                   status;
    logic [potq_pkg::ID_W-1:0]    task_id;
    logic [potq_pkg::BURST_W-1:0] burst;
    logic [potq_pkg::TIME_W-1:0]  finish_time;
    logic [potq_pkg::TIME_W-1:0]  wait_time;
    logic [potq_pkg::SUM_W-1:0]   turnaround_sum;
    logic [potq_pkg::SUM_W-1:0]   waiting_sum;
    logic [potq_pkg::DONE_W-1:0]  done_count;
    logic [potq_pkg::LEVEL_W-1:0] queue_level;
  } task_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_req_type = potq_pkg::REQ_ADD;
  logic [potq_pkg::ID_W-1:0]    in_task_id = '0;
  logic [potq_pkg::PRI_W-1:0]   in_task_priority = '0;
  logic [potq_pkg::BURST_W-1:0] in_task_burst = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [1:0]                   out_status;
  logic [potq_pkg::ID_W-1:0]    out_task_id;
  logic [potq_pkg::BURST_W-1:0] out_burst;
  logic [potq_pkg::TIME_W-1:0]  out_finish_time;
  logic [potq_pkg::TIME_W-1:0]  out_wait_time;
  logic [potq_pkg::SUM_W-1:0]   out_turnaround_sum;
  logic [potq_pkg::SUM_W-1:0]   out_waiting_sum;
  logic [potq_pkg::DONE_W-1:0]  out_done_count;
  logic [potq_pkg::LEVEL_W-1:0] out_queue_level;

  // scheduling model state: tasks held in service order, head first
  potq_pkg::slot_t             held_tasks[$];
  logic [potq_pkg::TIME_W-1:0] clock_ticks = '0;
  logic [potq_pkg::SUM_W-1:0]  turnaround_acc = '0;
  logic [potq_pkg::SUM_W-1:0]  waiting_acc = '0;
  logic [potq_pkg::DONE_W-1:0] dispatched_count = '0;

  task_result_t pending_results[$];
  int           mismatch_count = 0;

  // idling controls, switched off for the back-to-back burst run
  bit request_gaps_on = 1'b1;
  bit result_stalls_on = 1'b1;
  int stall_left = 0;

  priority_ordered_task_queue #(.QUEUE_DEPTH(TB_DEPTH)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_task_id         (in_task_id),
    .in_task_priority   (in_task_priority),
    .in_task_burst      (in_task_burst),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_task_id        (out_task_id),
    .out_burst          (out_burst),
    .out_finish_time    (out_finish_time),
    .out_wait_time      (out_wait_time),
    .out_turnaround_sum (out_turnaround_sum),
    .out_waiting_sum    (out_waiting_sum),
    .out_done_count     (out_done_count),
    .out_queue_level    (out_queue_level)
  );

  always #1 clk = ~clk;

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    else if (roll < 9) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic task_result_t schedule_request(logic req,
                                                    logic [potq_pkg::ID_W-1:0] id,
                                                    logic [potq_pkg::PRI_W-1:0] pri,
                                                    logic [potq_pkg::BURST_W-1:0] burst);
    task_result_t                r;
    potq_pkg::slot_t             entry;
    int                          pos;
    logic [potq_pkg::TIME_W:0]   ticks_next;
    logic [potq_pkg::SUM_W:0]    sum_next;
    r = '0;
    if (req == potq_pkg::REQ_ADD) begin
      if (held_tasks.size() >= TB_DEPTH) begin
        r.status = potq_pkg::STAT_FULL;
      end else begin
        // new task goes behind every task of greater or equal priority
        pos = 0;
        while (pos < held_tasks.size() && held_tasks[pos].pri >= pri) pos++;
        entry.id = id;
        entry.pri = pri;
        entry.burst = burst;
        held_tasks.insert(pos, entry);
        r.status = potq_pkg::STAT_ADDED;
      end
    end else if (held_tasks.size() == 0) begin
      r.status = potq_pkg::STAT_EMPTY;
    end else begin
      entry = held_tasks.pop_front();
      // elapsed ticks clamp at the 32-bit ceiling
      ticks_next = {1'b0, clock_ticks} + (potq_pkg::TIME_W + 1)'(entry.burst);
      clock_ticks = ticks_next[potq_pkg::TIME_W] ? '1 : ticks_next[potq_pkg::TIME_W-1:0];
      r.status = potq_pkg::STAT_DISPATCHED;
      r.task_id = entry.id;
      r.burst = entry.burst;
      r.finish_time = clock_ticks;
      r.wait_time = clock_ticks - potq_pkg::TIME_W'(entry.burst);
      sum_next = {1'b0, turnaround_acc} + (potq_pkg::SUM_W + 1)'(r.finish_time);
      turnaround_acc = sum_next[potq_pkg::SUM_W] ? '1 : sum_next[potq_pkg::SUM_W-1:0];
      sum_next = {1'b0, waiting_acc} + (potq_pkg::SUM_W + 1)'(r.wait_time);
      waiting_acc = sum_next[potq_pkg::SUM_W] ? '1 : sum_next[potq_pkg::SUM_W-1:0];
      if (dispatched_count != '1) dispatched_count++;
    end
    r.turnaround_sum = turnaround_acc;
    r.waiting_sum = waiting_acc;
    r.done_count = dispatched_count;
    r.queue_level = potq_pkg::LEVEL_W'(held_tasks.size());
    return r;
  endfunction

  // drives one request transaction, waits for its acceptance and records
  // what should come back; valid is only dropped when a gap is taken
  task automatic send_request(input logic req, input logic [potq_pkg::ID_W-1:0] id,
                              input logic [potq_pkg::PRI_W-1:0] pri,
                              input logic [potq_pkg::BURST_W-1:0] burst);
    int gap;
    gap = request_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_task_id <= id;
    in_task_priority <= pri;
    in_task_burst <= burst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(schedule_request(req, id, pri, burst));
  endtask

  // random request; priorities lean towards the ends and a few tie values,
  // bursts towards zero, full scale and short runs
  task automatic send_random_request(input int add_percent);
    logic                         req;
    logic [potq_pkg::PRI_W-1:0]   pri;
    logic [potq_pkg::BURST_W-1:0] burst;
    req = ($urandom_range(0, 99) < add_percent) ? potq_pkg::REQ_ADD : potq_pkg::REQ_DISPATCH;
    case ($urandom_range(0, 3))
      0: pri = potq_pkg::PRI_W'($urandom_range(0, 255));
      1: pri = potq_pkg::PRI_W'($urandom_range(0, 3));
      2: pri = potq_pkg::PRI_W'($urandom_range(252, 255));
      default: pri = 8'd128;
    endcase
    case ($urandom_range(0, 3))
      0: burst = potq_pkg::BURST_W'($urandom_range(0, 65535));
      1: burst = '0;
      2: burst = '1;
      default: burst = potq_pkg::BURST_W'($urandom_range(0, 15));
    endcase
    send_request(req, potq_pkg::ID_W'($urandom_range(0, 255)), pri, burst);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result side: random back-pressure on out_ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (result_stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // every accepted result transaction is matched against the oldest prediction
  always @(posedge clk) begin : result_check
    task_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result transaction with nothing outstanding, status %0d", out_status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("task_id", 64'(want.task_id), 64'(out_task_id));
        check_field("burst", 64'(want.burst), 64'(out_burst));
        check_field("finish_time", 64'(want.finish_time), 64'(out_finish_time));
        check_field("wait_time", 64'(want.wait_time), 64'(out_wait_time));
        check_field("turnaround_sum", 64'(want.turnaround_sum), 64'(out_turnaround_sum));
        check_field("waiting_sum", 64'(want.waiting_sum), 64'(out_waiting_sum));
        check_field("done_count", 64'(want.done_count), 64'(out_done_count));
        check_field("queue_level", 64'(want.queue_level), 64'(out_queue_level));
      end
    end
  end

  // dispatch straight out of reset hits the empty queue
  task automatic test_empty_dispatch();
    send_request(potq_pkg::REQ_DISPATCH, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  // fill the queue with extreme and tied priorities so that insertion has to
  // land at the head, the tail and between equals
  task automatic test_priority_insertion();
    send_request(potq_pkg::REQ_ADD, 8'h00, 8'd0,   16'h0000);
    send_request(potq_pkg::REQ_ADD, 8'hFF, 8'd255, 16'hFFFF);
    send_request(potq_pkg::REQ_ADD, 8'h01, 8'd128, 16'd1);
    send_request(potq_pkg::REQ_ADD, 8'h02, 8'd128, 16'd2);
    send_request(potq_pkg::REQ_ADD, 8'h03, 8'd255, 16'd3);
    send_request(potq_pkg::REQ_ADD, 8'h04, 8'd0,   16'h8000);
    send_request(potq_pkg::REQ_ADD, 8'hAA, 8'hAA,  16'hAAAA);
    send_request(potq_pkg::REQ_ADD, 8'h55, 8'h55,  16'h5555);
    send_request(potq_pkg::REQ_ADD, 8'h05, 8'd129, 16'd5);
    send_request(potq_pkg::REQ_ADD, 8'h06, 8'd127, 16'd6);
    send_request(potq_pkg::REQ_ADD, 8'h07, 8'd255, 16'd7);
    send_request(potq_pkg::REQ_ADD, 8'h08, 8'd1,   16'd8);
    send_request(potq_pkg::REQ_ADD, 8'h09, 8'd254, 16'd9);
    send_request(potq_pkg::REQ_ADD, 8'h0A, 8'd128, 16'd10);
    send_request(potq_pkg::REQ_ADD, 8'h0B, 8'd0,   16'd11);
    send_request(potq_pkg::REQ_ADD, 8'h0C, 8'd200, 16'h7FFF);
  endtask

  // queue is now at depth; adds at either priority extreme are refused
  task automatic test_full_reject();
    send_request(potq_pkg::REQ_ADD, 8'h5A, 8'd255, 16'hFFFF);
    send_request(potq_pkg::REQ_ADD, 8'hA5, 8'd0,   16'h0000);
  endtask

  // first dispatches come off the top-priority ties in arrival order
  task automatic test_dispatch_order();
    repeat (5) send_request(potq_pkg::REQ_DISPATCH, 8'h00, 8'h00, 16'h0000);
  endtask

  // random mix in phases that lean to filling, balance or draining
  task automatic test_random_traffic(input int count);
    int add_percent;
    add_percent = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: add_percent = 15;
          1: add_percent = 50;
          default: add_percent = 85;
        endcase
      end
      send_random_request(add_percent);
    end
  endtask

  // back-to-back add and dispatch pairs with full-scale bursts, no idling
  // on either side, so that elapsed time and both sums climb quickly
  task automatic test_back_to_back_bursts(input int pairs);
    request_gaps_on = 1'b0;
    result_stalls_on = 1'b0;
    for (int n = 0; n < pairs; n++) begin
      send_request(potq_pkg::REQ_ADD, potq_pkg::ID_W'($urandom_range(0, 255)),
                   potq_pkg::PRI_W'($urandom_range(0, 255)), 16'hFFFF);
      send_request(potq_pkg::REQ_DISPATCH, potq_pkg::ID_W'($urandom_range(0, 255)),
                   potq_pkg::PRI_W'($urandom_range(0, 255)),
                   potq_pkg::BURST_W'($urandom_range(0, 65535)));
    end
    request_gaps_on = 1'b1;
    result_stalls_on = 1'b1;
  endtask

  initial begin : run_tests
    int drain_cycles;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_dispatch();
    test_priority_insertion();
    test_full_reject();
    test_dispatch_order();
    test_random_traffic(900);
    test_back_to_back_bursts(40);

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 4000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("priority_ordered_task_queue: match");
    end else begin
      $display("priority_ordered_task_queue: mismatch");
    end
    $finish;
  end

  // watchdog, well beyond the gapped traffic with the longest stalls
  initial begin
    #8_000_000;
    $display("priority_ordered_task_queue: mismatch");
    $finish;
  end

endmodule
